@@ hw/rtl/spc_pkg.sv @@
// Shared constants and width helpers for the spot centroid accumulator.
package spc_pkg;

   // Number of finished spots that can wait between the accumulator and the divider.
   localparam int QUEUE_DEPTH = 2;

   // Width of the clamped photon total over a full spot.
   function automatic int ph_sum_w(input int photon_bits, input int max_pixels);
      return photon_bits - 1 + $clog2(max_pixels);
   endfunction

   // Width of a pixel counter that can hold the capacity itself.
   function automatic int count_w(input int max_pixels);
      return $clog2(max_pixels + 1);
   endfunction

endpackage

@@ hw/rtl/spc_if.sv @@
// Valid/ready channel interfaces for the pixel input and the spot result output.
interface spc_pixel_if #(
   parameter int COL_BITS    = 10,
   parameter int LINE_BITS   = 10,
   parameter int FRAME_BITS  = 20,
   parameter int PHOTON_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic [COL_BITS-1:0]           pixel_col;
   logic [LINE_BITS-1:0]          pixel_line;
   logic [FRAME_BITS-1:0]         frame_number;
   logic signed [PHOTON_BITS-1:0] photon_count;
   logic                          last_pixel;

   modport source (
      output valid, pixel_col, pixel_line, frame_number, photon_count, last_pixel,
      input  ready
   );
   modport sink (
      input  valid, pixel_col, pixel_line, frame_number, photon_count, last_pixel,
      output ready
   );
endinterface

interface spc_result_if #(
   parameter int COL_BITS    = 10,
   parameter int LINE_BITS   = 10,
   parameter int FRAME_BITS  = 20,
   parameter int PHOTON_BITS = 24,
   parameter int MAX_PIXELS  = 4096,
   parameter int FRAC_BITS   = 8
);
   localparam int SUM_PH_W = spc_pkg::ph_sum_w(PHOTON_BITS, MAX_PIXELS);
   localparam int CNT_W    = spc_pkg::count_w(MAX_PIXELS);

   logic                                valid;
   logic                                ready;
   logic [COL_BITS+FRAC_BITS-1:0]       centroid_col;
   logic [LINE_BITS+FRAC_BITS-1:0]      centroid_line;
   logic [FRAME_BITS+FRAC_BITS-1:0]     frame_centroid;
   logic [SUM_PH_W-1:0]                 total_photons;
   logic [PHOTON_BITS-2:0]              peak_photons;
   logic [CNT_W-1:0]                    pixels_in_spot;
   logic [COL_BITS+LINE_BITS:0]         box_area;
   logic [FRAME_BITS:0]                 frame_depth;
   logic                                zero_weight;
   logic                                pixel_overflow;

   modport source (
      output valid, centroid_col, centroid_line, frame_centroid, total_photons, peak_photons,
             pixels_in_spot, box_area, frame_depth, zero_weight, pixel_overflow,
      input  ready
   );
   modport sink (
      input  valid, centroid_col, centroid_line, frame_centroid, total_photons, peak_photons,
             pixels_in_spot, box_area, frame_depth, zero_weight, pixel_overflow,
      output ready
   );
endinterface

@@ hw/rtl/spc_divider.sv @@
// Restoring divider that produces one fixed-point quotient bit per cycle.
module spc_divider #(
   parameter int NUM_W   = 45,
   parameter int QUO_W   = 18,
   parameter int SHIFT   = 8,
   localparam int DEN_W  = NUM_W + SHIFT - QUO_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   localparam int DIVD_W = NUM_W + SHIFT;
   localparam int STEP_W = $clog2(QUO_W + 1);

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DIVD_W-1:0] dividend;
   logic [DEN_W:0]    shifted;
   logic [DEN_W:0]    diff;
   logic              fits;

   // The numerator is scaled by the fraction bits; its high part is already below the divisor.
   assign dividend = DIVD_W'(numer) << SHIFT;
   assign shifted  = {rem_ff, quo_ff[QUO_W-1]};
   assign diff     = shifted - {1'b0, den_ff};
   assign fits     = shifted >= {1'b0, den_ff};

   // One compare and subtract per cycle, quotient bits shift in from the right.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = dividend[DIVD_W-1:QUO_W];
         quo_in  = dividend[QUO_W-1:0];
         den_in  = denom;
         step_in = STEP_W'(QUO_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hw/rtl/spc_queue.sv @@
// Small first-in first-out queue of finished spot totals.
module spc_queue #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             push;
   logic             pop;

   assign push_ready = fill_ff != CNT_W'(DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/spc_front.sv @@
// Pixel front end: clamps counts, forms weighted products and accumulates the spot totals.
module spc_front #(
   parameter int COL_BITS      = 10,
   parameter int LINE_BITS     = 10,
   parameter int FRAME_BITS    = 20,
   parameter int PHOTON_BITS   = 24,
   parameter int MAX_PIXELS    = 4096,
   localparam int PH_W         = PHOTON_BITS - 1,
   localparam int SUM_PH_W     = spc_pkg::ph_sum_w(PHOTON_BITS, MAX_PIXELS),
   localparam int SUM_COL_W    = SUM_PH_W + COL_BITS,
   localparam int SUM_LINE_W   = SUM_PH_W + LINE_BITS,
   localparam int SUM_FRAME_W  = SUM_PH_W + FRAME_BITS,
   localparam int CNT_W        = spc_pkg::count_w(MAX_PIXELS)
) (
   input  logic                   clock,
   input  logic                   reset,
   spc_pixel_if.sink              req_chan,
   output logic                   snap_valid,
   input  logic                   snap_ready,
   output logic [SUM_COL_W-1:0]   snap_sum_col,
   output logic [SUM_LINE_W-1:0]  snap_sum_line,
   output logic [SUM_FRAME_W-1:0] snap_sum_frame,
   output logic [SUM_PH_W-1:0]    snap_sum_ph,
   output logic [PH_W-1:0]        snap_peak,
   output logic [CNT_W-1:0]       snap_count,
   output logic [COL_BITS-1:0]    snap_min_col,
   output logic [COL_BITS-1:0]    snap_max_col,
   output logic [LINE_BITS-1:0]   snap_low_line,
   output logic [LINE_BITS-1:0]   snap_high_line,
   output logic [FRAME_BITS-1:0]  snap_start_frame,
   output logic [FRAME_BITS-1:0]  snap_end_frame,
   output logic                   snap_overflow
);

   localparam int PCOL_W   = COL_BITS + PH_W;
   localparam int PLINE_W  = LINE_BITS + PH_W;
   localparam int PFRAME_W = FRAME_BITS + PH_W;
   localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_PIXELS);

   // Product stage registers.
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_last_ff;
   logic [COL_BITS-1:0]   s1_col_ff;
   logic [LINE_BITS-1:0]  s1_line_ff;
   logic [FRAME_BITS-1:0] s1_frame_ff;
   logic [PH_W-1:0]       s1_ph_ff;
   logic [PCOL_W-1:0]     s1_pcol_ff;
   logic [PLINE_W-1:0]    s1_pline_ff;
   logic [PFRAME_W-1:0]   s1_pframe_ff;

   // Accumulator registers.
   logic [SUM_COL_W-1:0]   sum_col_ff, sum_col_in;
   logic [SUM_LINE_W-1:0]  sum_line_ff, sum_line_in;
   logic [SUM_FRAME_W-1:0] sum_frame_ff, sum_frame_in;
   logic [SUM_PH_W-1:0]    sum_ph_ff, sum_ph_in;
   logic [PH_W-1:0]        peak_ff, peak_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [COL_BITS-1:0]    min_col_ff, min_col_in, max_col_ff, max_col_in;
   logic [LINE_BITS-1:0]   low_line_ff, low_line_in, high_line_ff, high_line_in;
   logic [FRAME_BITS-1:0]  start_frame_ff, start_frame_in, end_frame_ff, end_frame_in;
   logic                   ovf_ff, ovf_in;

   logic                   accept;
   logic                   s1_advance;
   logic [PH_W-1:0]        ph;
   logic                   room;

   // A negative count carries no weight.
   assign ph = req_chan.photon_count[PHOTON_BITS-1] ? '0 : req_chan.photon_count[PH_W-1:0];

   // The product stage moves on unless it holds a last pixel and the queue is full.
   assign s1_advance     = s1_valid_ff && (!s1_last_ff || snap_ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Weighted products, one multiplier per coordinate.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff   <= req_chan.last_pixel;
         s1_col_ff    <= req_chan.pixel_col;
         s1_line_ff   <= req_chan.pixel_line;
         s1_frame_ff  <= req_chan.frame_number;
         s1_ph_ff     <= ph;
         s1_pcol_ff   <= PCOL_W'(req_chan.pixel_col) * PCOL_W'(ph);
         s1_pline_ff  <= PLINE_W'(req_chan.pixel_line) * PLINE_W'(ph);
         s1_pframe_ff <= PFRAME_W'(req_chan.frame_number) * PFRAME_W'(ph);
      end
   end

   // Updated totals including the pixel in the product stage; a full spot only flags overflow.
   always_comb begin
      room             = cnt_ff != CAPACITY;
      snap_sum_col     = sum_col_ff;
      snap_sum_line    = sum_line_ff;
      snap_sum_frame   = sum_frame_ff;
      snap_sum_ph      = sum_ph_ff;
      snap_peak        = peak_ff;
      snap_count       = cnt_ff;
      snap_min_col     = min_col_ff;
      snap_max_col     = max_col_ff;
      snap_low_line    = low_line_ff;
      snap_high_line   = high_line_ff;
      snap_start_frame = start_frame_ff;
      snap_end_frame   = end_frame_ff;
      snap_overflow    = ovf_ff;
      if (room) begin
         snap_sum_col   = sum_col_ff + SUM_COL_W'(s1_pcol_ff);
         snap_sum_line  = sum_line_ff + SUM_LINE_W'(s1_pline_ff);
         snap_sum_frame = sum_frame_ff + SUM_FRAME_W'(s1_pframe_ff);
         snap_sum_ph    = sum_ph_ff + SUM_PH_W'(s1_ph_ff);
         snap_count     = cnt_ff + CNT_W'(1);
         if (s1_ph_ff > peak_ff) begin
            snap_peak = s1_ph_ff;
         end
         if (s1_col_ff < min_col_ff) begin
            snap_min_col = s1_col_ff;
         end
         if (s1_col_ff > max_col_ff) begin
            snap_max_col = s1_col_ff;
         end
         if (s1_line_ff < low_line_ff) begin
            snap_low_line = s1_line_ff;
         end
         if (s1_line_ff > high_line_ff) begin
            snap_high_line = s1_line_ff;
         end
         if (s1_frame_ff < start_frame_ff) begin
            snap_start_frame = s1_frame_ff;
         end
         if (s1_frame_ff > end_frame_ff) begin
            snap_end_frame = s1_frame_ff;
         end
      end else begin
         snap_overflow = 1'b1;
      end
   end

   // The last pixel hands the totals to the queue in the same cycle it is accumulated.
   assign snap_valid = s1_valid_ff && s1_last_ff;

   // Next accumulator state: hold, take the update, or clear after a last pixel.
   always_comb begin
      sum_col_in     = sum_col_ff;
      sum_line_in    = sum_line_ff;
      sum_frame_in   = sum_frame_ff;
      sum_ph_in      = sum_ph_ff;
      peak_in        = peak_ff;
      cnt_in         = cnt_ff;
      min_col_in     = min_col_ff;
      max_col_in     = max_col_ff;
      low_line_in    = low_line_ff;
      high_line_in   = high_line_ff;
      start_frame_in = start_frame_ff;
      end_frame_in   = end_frame_ff;
      ovf_in         = ovf_ff;
      if (s1_advance) begin
         if (s1_last_ff) begin
            sum_col_in     = '0;
            sum_line_in    = '0;
            sum_frame_in   = '0;
            sum_ph_in      = '0;
            peak_in        = '0;
            cnt_in         = '0;
            min_col_in     = '1;
            max_col_in     = '0;
            low_line_in    = '1;
            high_line_in   = '0;
            start_frame_in = '1;
            end_frame_in   = '0;
            ovf_in         = 1'b0;
         end else begin
            sum_col_in     = snap_sum_col;
            sum_line_in    = snap_sum_line;
            sum_frame_in   = snap_sum_frame;
            sum_ph_in      = snap_sum_ph;
            peak_in        = snap_peak;
            cnt_in         = snap_count;
            min_col_in     = snap_min_col;
            max_col_in     = snap_max_col;
            low_line_in    = snap_low_line;
            high_line_in   = snap_high_line;
            start_frame_in = snap_start_frame;
            end_frame_in   = snap_end_frame;
            ovf_in         = snap_overflow;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_col_ff     <= '0;
         sum_line_ff    <= '0;
         sum_frame_ff   <= '0;
         sum_ph_ff      <= '0;
         peak_ff        <= '0;
         cnt_ff         <= '0;
         min_col_ff     <= '1;
         max_col_ff     <= '0;
         low_line_ff    <= '1;
         high_line_ff   <= '0;
         start_frame_ff <= '1;
         end_frame_ff   <= '0;
         ovf_ff         <= 1'b0;
      end else begin
         sum_col_ff     <= sum_col_in;
         sum_line_ff    <= sum_line_in;
         sum_frame_ff   <= sum_frame_in;
         sum_ph_ff      <= sum_ph_in;
         peak_ff        <= peak_in;
         cnt_ff         <= cnt_in;
         min_col_ff     <= min_col_in;
         max_col_ff     <= max_col_in;
         low_line_ff    <= low_line_in;
         high_line_ff   <= high_line_in;
         start_frame_ff <= start_frame_in;
         end_frame_ff   <= end_frame_in;
         ovf_ff         <= ovf_in;
      end
   end

endmodule

@@ hw/rtl/spc_back.sv @@
// Result back end: divides the spot totals into centroids and forms box area and frame depth.
module spc_back #(
   parameter int COL_BITS      = 10,
   parameter int LINE_BITS     = 10,
   parameter int FRAME_BITS    = 20,
   parameter int PHOTON_BITS   = 24,
   parameter int MAX_PIXELS    = 4096,
   parameter int FRAC_BITS     = 8,
   localparam int PH_W         = PHOTON_BITS - 1,
   localparam int SUM_PH_W     = spc_pkg::ph_sum_w(PHOTON_BITS, MAX_PIXELS),
   localparam int SUM_COL_W    = SUM_PH_W + COL_BITS,
   localparam int SUM_LINE_W   = SUM_PH_W + LINE_BITS,
   localparam int SUM_FRAME_W  = SUM_PH_W + FRAME_BITS,
   localparam int CNT_W        = spc_pkg::count_w(MAX_PIXELS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   snap_valid,
   output logic                   snap_ready,
   input  logic [SUM_COL_W-1:0]   snap_sum_col,
   input  logic [SUM_LINE_W-1:0]  snap_sum_line,
   input  logic [SUM_FRAME_W-1:0] snap_sum_frame,
   input  logic [SUM_PH_W-1:0]    snap_sum_ph,
   input  logic [PH_W-1:0]        snap_peak,
   input  logic [CNT_W-1:0]       snap_count,
   input  logic [COL_BITS-1:0]    snap_min_col,
   input  logic [COL_BITS-1:0]    snap_max_col,
   input  logic [LINE_BITS-1:0]   snap_low_line,
   input  logic [LINE_BITS-1:0]   snap_high_line,
   input  logic [FRAME_BITS-1:0]  snap_start_frame,
   input  logic [FRAME_BITS-1:0]  snap_end_frame,
   input  logic                   snap_overflow,
   spc_result_if.source           rsp_chan
);

   localparam int QC_W    = COL_BITS + FRAC_BITS;
   localparam int QL_W    = LINE_BITS + FRAC_BITS;
   localparam int QF_W    = FRAME_BITS + FRAC_BITS;
   localparam int WID_W   = COL_BITS + 1;
   localparam int HGT_W   = LINE_BITS + 1;
   localparam int AREA_W  = COL_BITS + LINE_BITS + 1;
   localparam int DEPTH_W = FRAME_BITS + 1;

   typedef enum logic {IDLE, RUN} state_type;

   state_type           state_ff, state_in;

   // Totals held while the dividers run.
   logic [SUM_PH_W-1:0] sum_ph_ff, sum_ph_in;
   logic [PH_W-1:0]     peak_ff, peak_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [WID_W-1:0]    width_ff, width_in;
   logic [HGT_W-1:0]    height_ff, height_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic                ovf_ff, ovf_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [QC_W-1:0]     rsp_col_ff, rsp_col_in;
   logic [QL_W-1:0]     rsp_line_ff, rsp_line_in;
   logic [QF_W-1:0]     rsp_frame_ff, rsp_frame_in;
   logic [SUM_PH_W-1:0] rsp_total_ff, rsp_total_in;
   logic [PH_W-1:0]     rsp_peak_ff, rsp_peak_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [AREA_W-1:0]   rsp_area_ff, rsp_area_in;
   logic [DEPTH_W-1:0]  rsp_depth_ff, rsp_depth_in;
   logic                rsp_zero_ff, rsp_zero_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic                pop;
   logic                col_done, line_done, frame_done;
   logic [QC_W-1:0]     col_quo;
   logic [QL_W-1:0]     line_quo;
   logic [QF_W-1:0]     frame_quo;
   logic                zero;

   assign snap_ready = (state_ff == IDLE);
   assign pop        = snap_valid && snap_ready;
   assign zero       = sum_ph_ff == '0;

   // Three dividers run side by side, the frame one sets the time per spot.
   spc_divider #(.NUM_W(SUM_COL_W), .QUO_W(QC_W), .SHIFT(FRAC_BITS)) u_div_col (
      .clock    (clock),
      .reset    (reset),
      .start    (pop),
      .numer    (snap_sum_col),
      .denom    (snap_sum_ph),
      .done     (col_done),
      .quotient (col_quo)
   );

   spc_divider #(.NUM_W(SUM_LINE_W), .QUO_W(QL_W), .SHIFT(FRAC_BITS)) u_div_line (
      .clock    (clock),
      .reset    (reset),
      .start    (pop),
      .numer    (snap_sum_line),
      .denom    (snap_sum_ph),
      .done     (line_done),
      .quotient (line_quo)
   );

   spc_divider #(.NUM_W(SUM_FRAME_W), .QUO_W(QF_W), .SHIFT(FRAC_BITS)) u_div_frame (
      .clock    (clock),
      .reset    (reset),
      .start    (pop),
      .numer    (snap_sum_frame),
      .denom    (snap_sum_ph),
      .done     (frame_done),
      .quotient (frame_quo)
   );

   // Sequencing: take a spot, wait for the quotients and a free result register, then load it.
   always_comb begin
      state_in     = state_ff;
      sum_ph_in    = sum_ph_ff;
      peak_in      = peak_ff;
      cnt_in       = cnt_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      depth_in     = depth_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_col_in   = rsp_col_ff;
      rsp_line_in  = rsp_line_ff;
      rsp_frame_in = rsp_frame_ff;
      rsp_total_in = rsp_total_ff;
      rsp_peak_in  = rsp_peak_ff;
      rsp_count_in = rsp_count_ff;
      rsp_area_in  = rsp_area_ff;
      rsp_depth_in = rsp_depth_ff;
      rsp_zero_in  = rsp_zero_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         IDLE: begin
            if (pop) begin
               sum_ph_in = snap_sum_ph;
               peak_in   = snap_peak;
               cnt_in    = snap_count;
               ovf_in    = snap_overflow;
               width_in  = WID_W'(snap_max_col) - WID_W'(snap_min_col) + WID_W'(1);
               height_in = HGT_W'(snap_high_line) - HGT_W'(snap_low_line) + HGT_W'(1);
               depth_in  = DEPTH_W'(snap_end_frame) - DEPTH_W'(snap_start_frame)
                           + DEPTH_W'(1);
               state_in  = RUN;
            end
         end
         RUN: begin
            if (col_done && line_done && frame_done && !rsp_valid_in) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = zero ? '0 : col_quo;
               rsp_line_in  = zero ? '0 : line_quo;
               rsp_frame_in = zero ? '0 : frame_quo;
               rsp_total_in = sum_ph_ff;
               rsp_peak_in  = peak_ff;
               rsp_count_in = cnt_ff;
               rsp_area_in  = AREA_W'(width_ff) * AREA_W'(height_ff);
               rsp_depth_in = depth_ff;
               rsp_zero_in  = zero;
               rsp_ovf_in   = ovf_ff;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ph_ff    <= sum_ph_in;
         peak_ff      <= peak_in;
         cnt_ff       <= cnt_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         depth_ff     <= depth_in;
         ovf_ff       <= ovf_in;
         rsp_col_ff   <= rsp_col_in;
         rsp_line_ff  <= rsp_line_in;
         rsp_frame_ff <= rsp_frame_in;
         rsp_total_ff <= rsp_total_in;
         rsp_peak_ff  <= rsp_peak_in;
         rsp_count_ff <= rsp_count_in;
         rsp_area_ff  <= rsp_area_in;
         rsp_depth_ff <= rsp_depth_in;
         rsp_zero_ff  <= rsp_zero_in;
         rsp_ovf_ff   <= rsp_ovf_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.centroid_col   = rsp_col_ff;
   assign rsp_chan.centroid_line  = rsp_line_ff;
   assign rsp_chan.frame_centroid = rsp_frame_ff;
   assign rsp_chan.total_photons  = rsp_total_ff;
   assign rsp_chan.peak_photons   = rsp_peak_ff;
   assign rsp_chan.pixels_in_spot = rsp_count_ff;
   assign rsp_chan.box_area       = rsp_area_ff;
   assign rsp_chan.frame_depth    = rsp_depth_ff;
   assign rsp_chan.zero_weight    = rsp_zero_ff;
   assign rsp_chan.pixel_overflow = rsp_ovf_ff;

endmodule

@@ hw/rtl/spot_centroid_accumulator.sv @@
// Top level of the spot centroid accumulator: front end, spot queue and divider back end.
//
// Pixels of one spot enter one per cycle unless a last pixel waits on a full queue; the front
// end multiplies each count by its column, line and frame in one registered stage and adds
// it to the spot totals in the next. A pixel marked last sends the spot totals into a
// two-entry queue and clears the totals. The back end divides them with three restoring
// dividers side by side, one quotient bit per cycle. Spots that end faster than the back end
// divides them fill the queue, and the input then stalls until the back end takes a spot.
// The result stays registered until it is taken, while the back end already works on the
// next spot. Beyond MAX_PIXELS pixels a spot ignores further pixels and reports
// pixel_overflow; a spot with zero photons reports zero centroids and zero_weight.
module spot_centroid_accumulator #(
   parameter int COL_BITS    = 10,
   parameter int LINE_BITS   = 10,
   parameter int FRAME_BITS  = 20,
   parameter int PHOTON_BITS = 24,
   parameter int MAX_PIXELS  = 4096,
   parameter int FRAC_BITS   = 8
) (
   input  logic          clock,
   input  logic          reset,
   spc_pixel_if.sink     req_chan,
   spc_result_if.source  rsp_chan
);

   localparam int PH_W        = PHOTON_BITS - 1;
   localparam int SUM_PH_W    = spc_pkg::ph_sum_w(PHOTON_BITS, MAX_PIXELS);
   localparam int SUM_COL_W   = SUM_PH_W + COL_BITS;
   localparam int SUM_LINE_W  = SUM_PH_W + LINE_BITS;
   localparam int SUM_FRAME_W = SUM_PH_W + FRAME_BITS;
   localparam int CNT_W       = spc_pkg::count_w(MAX_PIXELS);

   // Totals of one finished spot as they travel through the queue.
   typedef struct packed {
      logic [SUM_COL_W-1:0]   sum_col;
      logic [SUM_LINE_W-1:0]  sum_line;
      logic [SUM_FRAME_W-1:0] sum_frame;
      logic [SUM_PH_W-1:0]    sum_ph;
      logic [PH_W-1:0]        peak;
      logic [CNT_W-1:0]       count;
      logic [COL_BITS-1:0]    min_col;
      logic [COL_BITS-1:0]    max_col;
      logic [LINE_BITS-1:0]   low_line;
      logic [LINE_BITS-1:0]   high_line;
      logic [FRAME_BITS-1:0]  start_frame;
      logic [FRAME_BITS-1:0]  end_frame;
      logic                   overflow;
   } snap_type;

   snap_type snap_in;
   snap_type snap_out;
   logic     push_valid, push_ready;
   logic     pop_valid, pop_ready;

   // Accumulation of incoming pixels.
   spc_front #(
      .COL_BITS    (COL_BITS),
      .LINE_BITS   (LINE_BITS),
      .FRAME_BITS  (FRAME_BITS),
      .PHOTON_BITS (PHOTON_BITS),
      .MAX_PIXELS  (MAX_PIXELS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .snap_valid       (push_valid),
      .snap_ready       (push_ready),
      .snap_sum_col     (snap_in.sum_col),
      .snap_sum_line    (snap_in.sum_line),
      .snap_sum_frame   (snap_in.sum_frame),
      .snap_sum_ph      (snap_in.sum_ph),
      .snap_peak        (snap_in.peak),
      .snap_count       (snap_in.count),
      .snap_min_col     (snap_in.min_col),
      .snap_max_col     (snap_in.max_col),
      .snap_low_line    (snap_in.low_line),
      .snap_high_line   (snap_in.high_line),
      .snap_start_frame (snap_in.start_frame),
      .snap_end_frame   (snap_in.end_frame),
      .snap_overflow    (snap_in.overflow)
   );

   // Queue of finished spots between the two halves.
   spc_queue #(
      .WIDTH ($bits(snap_type)),
      .DEPTH (spc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (snap_in),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (snap_out)
   );

   // Division and result formatting.
   spc_back #(
      .COL_BITS    (COL_BITS),
      .LINE_BITS   (LINE_BITS),
      .FRAME_BITS  (FRAME_BITS),
      .PHOTON_BITS (PHOTON_BITS),
      .MAX_PIXELS  (MAX_PIXELS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .snap_valid       (pop_valid),
      .snap_ready       (pop_ready),
      .snap_sum_col     (snap_out.sum_col),
      .snap_sum_line    (snap_out.sum_line),
      .snap_sum_frame   (snap_out.sum_frame),
      .snap_sum_ph      (snap_out.sum_ph),
      .snap_peak        (snap_out.peak),
      .snap_count       (snap_out.count),
      .snap_min_col     (snap_out.min_col),
      .snap_max_col     (snap_out.max_col),
      .snap_low_line    (snap_out.low_line),
      .snap_high_line   (snap_out.high_line),
      .snap_start_frame (snap_out.start_frame),
      .snap_end_frame   (snap_out.end_frame),
      .snap_overflow    (snap_out.overflow),
      .rsp_chan         (rsp_chan)
   );

endmodule
